// File: rtl/ggsc_pkg.sv
package ggsc_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int CORDIC_STEPS = 13;
	localparam int ANGLE_WIDTH = 16;
	localparam int HEADING_WIDTH = 15;
	localparam int GAIN_WIDTH = 16;
	localparam int REACH_WIDTH = 15;
	localparam int OUT_WIDTH = 24;
	localparam int ID_WIDTH = 8;
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int CFG_DATA_WIDTH = 16;

	localparam logic signed [ANGLE_WIDTH-1:0] PI_Q12 = 16'sd12868;
	localparam logic signed [ANGLE_WIDTH:0] TWO_PI_Q12 = 17'sd25736;
	localparam int SAT_MAX = 8388607;
	localparam int SAT_MIN = -8388608;

	localparam logic [1:0] CMD_POSE = 2'd0;
	localparam logic [1:0] CMD_TARGET = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;
	localparam logic [1:0] CMD_CATCH = 2'd3;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_LINEAR_GAIN = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_ANGULAR_GAIN = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_REACH_DISTANCE = 2'd2;

	localparam logic [GAIN_WIDTH-1:0] LINEAR_GAIN_RST = 16'd512;
	localparam logic [GAIN_WIDTH-1:0] ANGULAR_GAIN_RST = 16'd1536;
	localparam logic [REACH_WIDTH-1:0] REACH_DISTANCE_RST = 15'd128;

	typedef struct packed {
		logic done;
		logic reached;
	} fb_t;

	function automatic logic signed [ANGLE_WIDTH-1:0] atan_q12(input logic [3:0] idx);
		logic signed [ANGLE_WIDTH-1:0] a;
		case (idx)
			4'd0: a = 16'sd3217;
			4'd1: a = 16'sd1899;
			4'd2: a = 16'sd1003;
			4'd3: a = 16'sd509;
			4'd4: a = 16'sd256;
			4'd5: a = 16'sd128;
			4'd6: a = 16'sd64;
			4'd7: a = 16'sd32;
			4'd8: a = 16'sd16;
			4'd9: a = 16'sd8;
			4'd10: a = 16'sd4;
			4'd11: a = 16'sd2;
			4'd12: a = 16'sd1;
			default: a = 16'sd0;
		endcase
		return a;
	endfunction

endpackage

// File: rtl/ggsc_queue.sv
module ggsc_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_valid,
	output logic         wr_ready,
	input  logic [W-1:0] wr_data,
	output logic         rd_valid,
	input  logic         rd_ready,
	output logic [W-1:0] rd_data
);

	logic [W-1:0] mem_q [2];
	logic [1:0]   vld_q;
	logic         wp_q;
	logic         rp_q;
	logic         push;
	logic         pop;

	assign wr_ready = !vld_q[wp_q];
	assign rd_valid = vld_q[rp_q];
	assign rd_data = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (push) begin
				vld_q[wp_q] <= 1'b1;
				wp_q <= !wp_q;
			end
			if (pop) begin
				vld_q[rp_q] <= 1'b0;
				rp_q <= !rp_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_data;
		end
	end

endmodule

// File: rtl/ggsc_front.sv
module ggsc_front #(
	parameter int CW = ggsc_pkg::COORD_WIDTH_DEF,
	parameter int JW = 2 * (CW + 1) + ggsc_pkg::HEADING_WIDTH + ggsc_pkg::ID_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           command,
	input  logic [CW-1:0]                        pose_x,
	input  logic [CW-1:0]                        pose_y,
	input  logic [ggsc_pkg::HEADING_WIDTH-1:0]   pose_heading,
	input  logic [CW-1:0]                        target_x,
	input  logic [CW-1:0]                        target_y,
	input  logic [ggsc_pkg::ID_WIDTH-1:0]        target_id,
	input  logic                                 target_present,
	output logic                                 q_valid,
	input  logic                                 q_ready,
	output logic [JW-1:0]                        q_data,
	input  ggsc_pkg::fb_t                        fb
);

	logic [CW-1:0]                      px_q;
	logic [CW-1:0]                      py_q;
	logic [ggsc_pkg::HEADING_WIDTH-1:0] hd_q;
	logic [CW-1:0]                      tx_q;
	logic [CW-1:0]                      ty_q;
	logic [ggsc_pkg::ID_WIDTH-1:0]      id_q;
	logic                               have_pose_q;
	logic                               have_target_q;
	logic                               seeking_q;
	logic                               busy_q;
	logic                               acc;
	logic signed [CW:0]                 dx;
	logic signed [CW:0]                 dy;

	assign in_ready = !busy_q && q_ready;
	assign acc = in_valid && in_ready;
	assign dx = $signed({tx_q[CW-1], tx_q}) - $signed({px_q[CW-1], px_q});
	assign dy = $signed({ty_q[CW-1], ty_q}) - $signed({py_q[CW-1], py_q});
	assign q_data = {dx, dy, hd_q, id_q};
	assign q_valid = acc && (command == ggsc_pkg::CMD_TICK) && have_pose_q && have_target_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_pose_q <= 1'b0;
			have_target_q <= 1'b0;
			seeking_q <= 1'b1;
			busy_q <= 1'b0;
			px_q <= '0;
			py_q <= '0;
			hd_q <= '0;
			tx_q <= '0;
			ty_q <= '0;
			id_q <= '0;
		end else begin
			if (fb.done) begin
				busy_q <= 1'b0;
				if (fb.reached) begin
					have_pose_q <= 1'b0;
					have_target_q <= 1'b0;
					seeking_q <= 1'b0;
				end
			end
			if (acc) begin
				case (command)
					ggsc_pkg::CMD_POSE: begin
						px_q <= pose_x;
						py_q <= pose_y;
						hd_q <= pose_heading;
						have_pose_q <= 1'b1;
					end
					ggsc_pkg::CMD_TARGET: begin
						if (seeking_q && target_present) begin
							tx_q <= target_x;
							ty_q <= target_y;
							id_q <= target_id;
							have_target_q <= 1'b1;
						end
					end
					ggsc_pkg::CMD_CATCH: begin
						seeking_q <= 1'b1;
					end
					default: begin
						if (have_pose_q && have_target_q) begin
							busy_q <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !acc)
		else $error("word accepted while a tick is in flight");

	a_done_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fb.done |-> busy_q)
		else $error("tick completion without a pending tick");

endmodule

// File: rtl/ggsc_back.sv
module ggsc_back #(
	parameter int CW = ggsc_pkg::COORD_WIDTH_DEF,
	parameter int JW = 2 * (CW + 1) + ggsc_pkg::HEADING_WIDTH + ggsc_pkg::ID_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_valid,
	output logic                                q_ready,
	input  logic [JW-1:0]                       q_data,
	output ggsc_pkg::fb_t                       fb,
	input  logic [ggsc_pkg::GAIN_WIDTH-1:0]     lin_gain,
	input  logic [ggsc_pkg::GAIN_WIDTH-1:0]     ang_gain,
	input  logic [ggsc_pkg::REACH_WIDTH-1:0]    reach,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ggsc_pkg::OUT_WIDTH-1:0]      linear_speed,
	output logic [ggsc_pkg::OUT_WIDTH-1:0]      angular_rate,
	output logic                                catch_request,
	output logic [ggsc_pkg::ID_WIDTH-1:0]       catch_id,
	output logic                                last
);

	localparam int RW = CW + 1;
	localparam int SW = 2 * RW;
	localparam int XW = CW + 12;
	localparam int CNTW = $clog2(RW);
	localparam int AW = ggsc_pkg::ANGLE_WIDTH;
	localparam int EW = AW + 1;
	localparam int HW = ggsc_pkg::HEADING_WIDTH;
	localparam int IW = ggsc_pkg::ID_WIDTH;
	localparam int GW = ggsc_pkg::GAIN_WIDTH;
	localparam int OW = ggsc_pkg::OUT_WIDTH;
	localparam int LPW = GW + RW;
	localparam int LW = LPW - 8;
	localparam int APW = GW + 1 + EW;
	localparam int ASW = APW - 8;
	localparam int CMPW = RW + ggsc_pkg::REACH_WIDTH;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SQA = 4'd1;
	localparam logic [3:0] ST_SQB = 4'd2;
	localparam logic [3:0] ST_RUN = 4'd3;
	localparam logic [3:0] ST_ERR = 4'd4;
	localparam logic [3:0] ST_MUL = 4'd5;
	localparam logic [3:0] ST_FIN = 4'd6;
	localparam logic [3:0] ST_EMIT1 = 4'd7;
	localparam logic [3:0] ST_EMIT2 = 4'd8;

	logic [3:0]              state_q;
	logic [CNTW-1:0]         cnt_q;
	logic [RW-1:0]           ax_q;
	logic [RW-1:0]           ay_q;
	logic [SW-1:0]           s_q;
	logic [RW+1:0]           rem_q;
	logic [RW-1:0]           root_q;
	logic signed [XW-1:0]    x_q;
	logic signed [XW-1:0]    y_q;
	logic signed [AW-1:0]    z_q;
	logic                    zero_q;
	logic [HW-1:0]           hd_q;
	logic [IW-1:0]           id_q;
	logic signed [EW-1:0]    err_q;
	logic [RW-1:0]           dist_q;
	logic [LPW-1:0]          lin_p_q;
	logic signed [APW-1:0]   ang_p_q;
	logic                    reached_q;
	logic [OW-1:0]           lin_q;
	logic [OW-1:0]           ang_q;
	logic                    req_q;
	logic [IW-1:0]           cid_q;
	logic                    last_q;

	logic signed [CW:0]      j_dx;
	logic signed [CW:0]      j_dy;
	logic [HW-1:0]           j_hd;
	logic [IW-1:0]           j_id;
	logic signed [XW-1:0]    ext_dx;
	logic signed [XW-1:0]    ext_dy;
	logic [RW-1:0]           mop;
	logic [SW-1:0]           sq;
	logic [RW+1:0]           rem_sh;
	logic [RW+1:0]           trial;
	logic signed [XW-1:0]    xs;
	logic signed [XW-1:0]    ys;
	logic signed [AW-1:0]    bearing;
	logic signed [EW-1:0]    e0;
	logic signed [EW-1:0]    e1;
	logic signed [EW-1:0]    e2;
	logic [LW-1:0]           lin_sh;
	logic [LW+OW-1:0]        lin_x;
	logic signed [ASW-1:0]   ang_sh;
	logic                    reached;
	logic                    out_acc;

	assign {j_dx, j_dy, j_hd, j_id} = q_data;
	assign q_ready = (state_q == ST_IDLE);
	assign ext_dx = XW'(j_dx) <<< 8;
	assign ext_dy = XW'(j_dy) <<< 8;

	assign mop = (state_q == ST_SQA) ? ax_q : ay_q;
	assign sq = SW'(mop) * SW'(mop);

	assign rem_sh = {rem_q[RW-1:0], s_q[SW-1:SW-2]};
	assign trial = {root_q, 2'b01};
	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;

	assign bearing = zero_q ? '0 : z_q;
	assign e0 = EW'(bearing) - EW'($signed(hd_q));
	assign e1 = (e0 > EW'(ggsc_pkg::PI_Q12)) ? e0 - ggsc_pkg::TWO_PI_Q12 : e0;
	assign e2 = (e1 < -EW'(ggsc_pkg::PI_Q12)) ? e1 + ggsc_pkg::TWO_PI_Q12 : e1;

	assign lin_sh = lin_p_q[LPW-1:8];
	assign lin_x = (LW+OW)'(lin_sh);
	assign ang_sh = ang_p_q[APW-1:8];
	assign reached = CMPW'(dist_q) < CMPW'(reach);

	assign out_valid = (state_q == ST_EMIT1) || (state_q == ST_EMIT2);
	assign out_acc = out_valid && out_ready;
	assign fb.done = (state_q == ST_FIN);
	assign fb.reached = reached;

	assign linear_speed = lin_q;
	assign angular_rate = ang_q;
	assign catch_request = req_q;
	assign catch_id = cid_q;
	assign last = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_SQA;
					end
				end
				ST_SQA: state_q <= ST_SQB;
				ST_SQB: begin
					cnt_q <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNTW'(RW - 1)) begin
						state_q <= ST_ERR;
					end
				end
				ST_ERR: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_FIN;
				ST_FIN: state_q <= ST_EMIT1;
				ST_EMIT1: begin
					if (out_acc) begin
						state_q <= reached_q ? ST_EMIT2 : ST_IDLE;
					end
				end
				ST_EMIT2: begin
					if (out_acc) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ax_q <= j_dx[CW] ? RW'(-j_dx) : RW'(j_dx);
				ay_q <= j_dy[CW] ? RW'(-j_dy) : RW'(j_dy);
				hd_q <= j_hd;
				id_q <= j_id;
				zero_q <= (j_dx == '0) && (j_dy == '0);
				if (j_dx[CW]) begin
					x_q <= -ext_dx;
					y_q <= -ext_dy;
					z_q <= j_dy[CW] ? -ggsc_pkg::PI_Q12 : ggsc_pkg::PI_Q12;
				end else begin
					x_q <= ext_dx;
					y_q <= ext_dy;
					z_q <= '0;
				end
			end
			ST_SQA: s_q <= sq;
			ST_SQB: begin
				s_q <= s_q + sq;
				rem_q <= '0;
				root_q <= '0;
			end
			ST_RUN: begin
				s_q <= s_q << 2;
				if (rem_sh >= trial) begin
					rem_q <= rem_sh - trial;
					root_q <= {root_q[RW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					root_q <= {root_q[RW-2:0], 1'b0};
				end
				if (32'(cnt_q) < ggsc_pkg::CORDIC_STEPS) begin
					if (!y_q[XW-1]) begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + ggsc_pkg::atan_q12(4'(cnt_q));
					end else begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - ggsc_pkg::atan_q12(4'(cnt_q));
					end
				end
			end
			ST_ERR: begin
				err_q <= e2;
				dist_q <= root_q;
			end
			ST_MUL: begin
				lin_p_q <= LPW'(lin_gain) * LPW'(dist_q);
				ang_p_q <= $signed({1'b0, ang_gain}) * err_q;
			end
			ST_FIN: begin
				reached_q <= reached;
				lin_q <= (lin_x > (LW+OW)'(ggsc_pkg::SAT_MAX)) ? OW'(ggsc_pkg::SAT_MAX)
					: OW'(lin_sh);
				if (ang_sh > ASW'(ggsc_pkg::SAT_MAX)) begin
					ang_q <= OW'(ggsc_pkg::SAT_MAX);
				end else if (ang_sh < ASW'(ggsc_pkg::SAT_MIN)) begin
					ang_q <= OW'(ggsc_pkg::SAT_MIN);
				end else begin
					ang_q <= OW'(ang_sh);
				end
				req_q <= 1'b0;
				cid_q <= '0;
				last_q <= !reached;
			end
			ST_EMIT1: begin
				if (out_acc) begin
					lin_q <= '0;
					ang_q <= '0;
					req_q <= 1'b1;
					cid_q <= id_q;
					last_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	a_catch_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT2) |-> (req_q && last_q && lin_q == '0 && ang_q == '0))
		else $error("catch word malformed");

	a_first_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT1) |-> (!req_q && (last_q == !reached_q)))
		else $error("command word flags disagree with reach result");

	a_reach_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		fb.done |=> (state_q == ST_EMIT1 && reached_q == $past(reached)))
		else $error("reach result not carried to output stage");

endmodule

// File: rtl/go_to_goal_steering_controller.sv
// A tick with pose and target held is queued, then passes SQA, SQB, RUN (bit-serial
// square root and CORDIC together), ERR, MUL and FIN before its first word is offered.
// A new tick is taken only once the last one reaches FIN, so output stalls can slow ticks;
// pose, target and catch-reply words are taken one per cycle while no tick is in flight.
// Reset (arst_n low, asynchronous): gains 2.0 and 6.0, reach 0.5, no pose, no target,
// seeking set, queue and output empty.
module go_to_goal_steering_controller #(
	parameter int COORD_WIDTH = ggsc_pkg::COORD_WIDTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_write,
	input  logic [ggsc_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
	input  logic [ggsc_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [1:0]                              command,
	input  logic [COORD_WIDTH-1:0]                  pose_x,
	input  logic [COORD_WIDTH-1:0]                  pose_y,
	input  logic [ggsc_pkg::HEADING_WIDTH-1:0]      pose_heading,
	input  logic [COORD_WIDTH-1:0]                  target_x,
	input  logic [COORD_WIDTH-1:0]                  target_y,
	input  logic [ggsc_pkg::ID_WIDTH-1:0]           target_id,
	input  logic                                    target_present,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [ggsc_pkg::OUT_WIDTH-1:0]          linear_speed,
	output logic [ggsc_pkg::OUT_WIDTH-1:0]          angular_rate,
	output logic                                    catch_request,
	output logic [ggsc_pkg::ID_WIDTH-1:0]           catch_id,
	output logic                                    last
);

	localparam int JW = 2 * (COORD_WIDTH + 1) + ggsc_pkg::HEADING_WIDTH + ggsc_pkg::ID_WIDTH;

	logic [ggsc_pkg::GAIN_WIDTH-1:0]  lin_gain_q;
	logic [ggsc_pkg::GAIN_WIDTH-1:0]  ang_gain_q;
	logic [ggsc_pkg::REACH_WIDTH-1:0] reach_q;
	logic                             fq_valid;
	logic                             fq_ready;
	logic [JW-1:0]                    fq_data;
	logic                             bq_valid;
	logic                             bq_ready;
	logic [JW-1:0]                    bq_data;
	ggsc_pkg::fb_t                    fb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_gain_q <= ggsc_pkg::LINEAR_GAIN_RST;
			ang_gain_q <= ggsc_pkg::ANGULAR_GAIN_RST;
			reach_q <= ggsc_pkg::REACH_DISTANCE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				ggsc_pkg::REG_LINEAR_GAIN: lin_gain_q <= cfg_data;
				ggsc_pkg::REG_ANGULAR_GAIN: ang_gain_q <= cfg_data;
				ggsc_pkg::REG_REACH_DISTANCE: reach_q <= cfg_data[ggsc_pkg::REACH_WIDTH-1:0];
				default: begin
				end
			endcase
		end
	end

	ggsc_front #(
		.CW(COORD_WIDTH),
		.JW(JW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.pose_x(pose_x),
		.pose_y(pose_y),
		.pose_heading(pose_heading),
		.target_x(target_x),
		.target_y(target_y),
		.target_id(target_id),
		.target_present(target_present),
		.q_valid(fq_valid),
		.q_ready(fq_ready),
		.q_data(fq_data),
		.fb(fb)
	);

	ggsc_queue #(
		.W(JW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_valid(fq_valid),
		.wr_ready(fq_ready),
		.wr_data(fq_data),
		.rd_valid(bq_valid),
		.rd_ready(bq_ready),
		.rd_data(bq_data)
	);

	ggsc_back #(
		.CW(COORD_WIDTH),
		.JW(JW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(bq_valid),
		.q_ready(bq_ready),
		.q_data(bq_data),
		.fb(fb),
		.lin_gain(lin_gain_q),
		.ang_gain(ang_gain_q),
		.reach(reach_q),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.linear_speed(linear_speed),
		.angular_rate(angular_rate),
		.catch_request(catch_request),
		.catch_id(catch_id),
		.last(last)
	);

endmodule

// File: tb/sv/testbench.sv
module testbench;

	localparam int CW = 16;
	localparam int ATAN_TAB [13] = '{3217, 1899, 1003, 509, 256, 128, 64, 32, 16, 8, 4, 2, 1};

	typedef struct {
		logic [23:0] speed;
		logic [23:0] rate;
		logic        req;
		logic [7:0]  id;
		logic        fin;
	} steer_word_t;

	int error_count = 0;

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		error_count++;
	endtask

	class steer_scoreboard;
		steer_word_t pending[$];
		int unsigned lin_gain, ang_gain, reach;
		longint px, py, hd, tx, ty;
		int unsigned tid;
		bit have_pose, have_target, seeking;

		function void clear();
			lin_gain = 512; ang_gain = 1536; reach = 128;
			px = 0; py = 0; hd = 0; tx = 0; ty = 0; tid = 0;
			have_pose = 0; have_target = 0; seeking = 1;
		endfunction

		function void set_reg(int idx, int unsigned v);
			if (idx == ggsc_pkg::REG_LINEAR_GAIN) lin_gain = v & 16'hffff;
			else if (idx == ggsc_pkg::REG_ANGULAR_GAIN) ang_gain = v & 16'hffff;
			else if (idx == ggsc_pkg::REG_REACH_DISTANCE) reach = v & 15'h7fff;
		endfunction

		function longint isqrt(longint s);
			longint r;
			longint c;
			r = 0;
			for (int b = 30; b >= 0; b--) begin
				c = r | (64'sd1 << b);
				if (c * c <= s) r = c;
			end
			return r;
		endfunction

		function longint bearing(longint dx, longint dy);
			longint x, y, z, xs, ys;
			x = dx * 256; y = dy * 256; z = 0;
			if (dx == 0 && dy == 0) return 0;
			if (x < 0) begin
				z = (dy >= 0) ? 12868 : -12868;
				x = -x; y = -y;
			end
			for (int i = 0; i < 13; i++) begin
				xs = x >>> i; ys = y >>> i;
				if (y >= 0) begin
					x += ys; y -= xs; z += ATAN_TAB[i];
				end else begin
					x -= ys; y += xs; z -= ATAN_TAB[i];
				end
			end
			return z;
		endfunction

		function void note_word(logic [1:0] cmd, logic signed [15:0] ix, logic signed [15:0] iy,
				logic signed [14:0] ih, logic signed [15:0] itx, logic signed [15:0] ity,
				logic [7:0] iid, logic pres);
			longint dx, dy, dlen, err, lin, ang;
			steer_word_t w;
			case (cmd)
				ggsc_pkg::CMD_POSE: begin
					px = ix; py = iy; hd = ih; have_pose = 1;
				end
				ggsc_pkg::CMD_TARGET: begin
					if (seeking && pres) begin
						tx = itx; ty = ity; tid = iid; have_target = 1;
					end
				end
				ggsc_pkg::CMD_CATCH: seeking = 1;
				default: begin
					if (have_pose && have_target) begin
						dx = tx - px; dy = ty - py;
						dlen = isqrt(dx * dx + dy * dy);
						err = bearing(dx, dy) - hd;
						if (err > 12868) err -= 25736;
						if (err < -12868) err += 25736;
						lin = (longint'(lin_gain) * dlen) >>> 8;
						if (lin > ggsc_pkg::SAT_MAX) lin = ggsc_pkg::SAT_MAX;
						ang = (longint'(ang_gain) * err) >>> 8;
						if (ang > ggsc_pkg::SAT_MAX) ang = ggsc_pkg::SAT_MAX;
						if (ang < ggsc_pkg::SAT_MIN) ang = ggsc_pkg::SAT_MIN;
						w.speed = lin[23:0]; w.rate = ang[23:0];
						w.req = 0; w.id = 0; w.fin = !(dlen < reach);
						pending.push_back(w);
						if (dlen < reach) begin
							w.speed = 0; w.rate = 0; w.req = 1; w.id = tid; w.fin = 1;
							pending.push_back(w);
							have_pose = 0; have_target = 0; seeking = 0;
						end
					end
				end
			endcase
		endfunction

		task check_word(steer_word_t got);
			steer_word_t w;
			if (pending.size() == 0) begin
				report("unexpected word", got.speed, 0);
				return;
			end
			w = pending.pop_front();
			if (got.speed !== w.speed) report("linear_speed", got.speed, w.speed);
			if (got.rate !== w.rate) report("angular_rate", got.rate, w.rate);
			if (got.req !== w.req) report("catch_request", got.req, w.req);
			if (got.id !== w.id) report("catch_id", got.id, w.id);
			if (got.fin !== w.fin) report("last", got.fin, w.fin);
		endtask
	endclass

	logic clk = 0, arst_n = 0;
	logic cfg_write = 0;
	logic [ggsc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = 0;
	logic [ggsc_pkg::CFG_DATA_WIDTH-1:0] cfg_data = 0;
	logic in_valid = 0, in_ready;
	logic [1:0] command = 0;
	logic [CW-1:0] pose_x = 0, pose_y = 0, target_x = 0, target_y = 0;
	logic [ggsc_pkg::HEADING_WIDTH-1:0] pose_heading = 0;
	logic [ggsc_pkg::ID_WIDTH-1:0] target_id = 0;
	logic target_present = 0;
	logic out_valid, out_ready = 0;
	logic [ggsc_pkg::OUT_WIDTH-1:0] linear_speed, angular_rate;
	logic catch_request, last;
	logic [ggsc_pkg::ID_WIDTH-1:0] catch_id;

	steer_scoreboard sb = new();
	int idle_pct = 25;
	int hold_cycles = 0;

	go_to_goal_steering_controller u_top (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		if (in_valid && in_ready)
			sb.note_word(command, pose_x, pose_y, pose_heading, target_x, target_y,
				target_id, target_present);
		if (out_valid && out_ready)
			sb.check_word('{linear_speed, angular_rate, catch_request, catch_id, last});
	end

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 0;
		end else
			out_ready <= ($urandom_range(99) >= idle_pct);
	end

	task automatic send(input logic [1:0] c, input logic [15:0] x, input logic [15:0] y,
			input logic [14:0] h, input logic [15:0] gx, input logic [15:0] gy,
			input logic [7:0] id, input logic p);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		command <= c; pose_x <= x; pose_y <= y; pose_heading <= h;
		target_x <= gx; target_y <= gy; target_id <= id; target_present <= p;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
		cfg_write <= 1; cfg_index <= idx; cfg_data <= v;
		@(posedge clk);
		cfg_write <= 0;
		sb.set_reg(idx, v);
		@(posedge clk);
	endtask

	function automatic logic [15:0] near(logic [15:0] c);
		return c + 16'($signed($urandom_range(200)) - 100);
	endfunction

	task automatic rand_items(input int n);
		logic [15:0] x, y, gx, gy;
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			x = 16'($urandom); y = 16'($urandom);
			gx = (k < 40) ? near(x) : 16'($urandom);
			gy = (k < 40) ? near(y) : 16'($urandom);
			if (k < 80) begin
				send(ggsc_pkg::CMD_POSE, x, y, 15'($urandom_range(25736)) - 15'd12868,
					0, 0, 0, 0);
				send(ggsc_pkg::CMD_TARGET, 16'($urandom), 16'($urandom), 15'($urandom),
					gx, gy, 8'($urandom), $urandom_range(9) != 0);
				send(ggsc_pkg::CMD_TICK, 16'($urandom), 16'($urandom), 15'($urandom),
					16'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
				if ($urandom_range(3) == 0) send(ggsc_pkg::CMD_CATCH, 16'($urandom),
					16'($urandom), 15'($urandom), 16'($urandom), 16'($urandom),
					8'($urandom), 1'($urandom));
				i += 2;
			end else
				send(2'($urandom), 16'($urandom), 16'($urandom), 15'($urandom),
					16'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		sb.clear();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed
		send(ggsc_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
		send(ggsc_pkg::CMD_TARGET, 0, 0, 0, 16'h0100, 0, 8'h11, 0);
		send(ggsc_pkg::CMD_POSE, 0, 0, 0, 0, 0, 0, 0);
		send(ggsc_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
		send(ggsc_pkg::CMD_TARGET, 0, 0, 0, 0, 0, 8'hff, 1);
		send(ggsc_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
		send(ggsc_pkg::CMD_TARGET, 0, 0, 0, 16'h7fff, 16'h7fff, 8'h22, 1);
		send(ggsc_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
		send(ggsc_pkg::CMD_CATCH, 0, 0, 0, 0, 0, 0, 0);
		send(ggsc_pkg::CMD_POSE, 16'h7fff, 16'h7fff, 15'h7fff, 0, 0, 0, 0);
		send(ggsc_pkg::CMD_TARGET, 0, 0, 0, 16'h8000, 16'h8000, 8'h5a, 1);
		send(ggsc_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
		send(ggsc_pkg::CMD_POSE, 16'h8000, 16'h7fff, 15'h4000, 0, 0, 0, 0);
		send(ggsc_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
		send(ggsc_pkg::CMD_POSE, 16'h0, 16'h0, -15'sd12868, 0, 0, 0, 0);
		send(ggsc_pkg::CMD_TARGET, 0, 0, 0, 16'hff00, 16'h0, 8'h01, 1);
		send(ggsc_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
		send(ggsc_pkg::CMD_TARGET, 0, 0, 0, 16'hff00, 16'hffff, 8'h02, 1);
		send(ggsc_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
		send(ggsc_pkg::CMD_TARGET, 0, 0, 0, 16'h0050, 16'h0010, 8'h03, 1);
		send(ggsc_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
		drain();
		write_reg(ggsc_pkg::REG_LINEAR_GAIN, 16'hffff);
		write_reg(ggsc_pkg::REG_ANGULAR_GAIN, 16'hffff);
		write_reg(ggsc_pkg::REG_REACH_DISTANCE, 16'h7fff);
		write_reg(2'd3, 16'h1234);
		rand_items(150);
		drain();
		write_reg(ggsc_pkg::REG_LINEAR_GAIN, 16'h0000);
		write_reg(ggsc_pkg::REG_ANGULAR_GAIN, 16'h0000);
		write_reg(ggsc_pkg::REG_REACH_DISTANCE, 16'h0000);
		idle_pct = 0;
		rand_items(250);
		drain();
		write_reg(ggsc_pkg::REG_LINEAR_GAIN, 16'($urandom));
		write_reg(ggsc_pkg::REG_ANGULAR_GAIN, 16'($urandom));
		write_reg(ggsc_pkg::REG_REACH_DISTANCE, 16'($urandom_range(2000)));
		idle_pct = 25;
		hold_cycles = 400;
		rand_items(200);
		drain();
		write_reg(ggsc_pkg::REG_LINEAR_GAIN, 16'd512);
		write_reg(ggsc_pkg::REG_ANGULAR_GAIN, 16'd1536);
		write_reg(ggsc_pkg::REG_REACH_DISTANCE, 16'd128);
		rand_items(780);
		drain();
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#3000000;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
